@@ rtl/core/mlt_pkg.sv @@
// Shared types and constants of the metric line tokenizer.
package mlt_pkg;

    typedef enum logic [2:0] {
        PH_KEY     = 3'd0,
        PH_LABEL   = 3'd1,
        PH_AFTER   = 3'd2,
        PH_VALUE   = 3'd3,
        PH_LINEEND = 3'd4,
        PH_DISCARD = 3'd5
    } t_phase;

    typedef enum logic [2:0] {
        ROLE_KEY   = 3'd0,
        ROLE_LKEY  = 3'd1,
        ROLE_LVAL  = 3'd2,
        ROLE_VALUE = 3'd3,
        ROLE_DELIM = 3'd4,
        ROLE_DROP  = 3'd5
    } t_role;

    typedef enum logic [2:0] {
        ERR_NONE       = 3'd0,
        ERR_KEY_EQUALS = 3'd1,
        ERR_BAD_LABEL  = 3'd2,
        ERR_AFTER_LBL  = 3'd3,
        ERR_INCOMPLETE = 3'd4
    } t_err;

    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_EQUALS = 8'h3D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_NUL    = 8'h00;

    typedef struct packed {
        t_phase phase;
        logic   split_seen;
        logic   value_nonempty;
    } t_parse_state;

    typedef struct packed {
        t_role role;
        logic  sample_done;
        t_err  error_code;
    } t_tag;

endpackage

@@ rtl/core/metric_line_tokenizer_core.sv @@
// Top level of the metric line tokenizer: input register, tagging logic, result register.
//
//   channel | direction | handshake             | word
//   in      | input     | i_in_valid/o_in_stall | data byte, last of message
//   out     | output    | o_out_valid/i_out_stall | byte, role, sample done, error, msg done
//
// One byte per cycle while the output does not stall; a word passes through the input
// register and then the result register around the tagger on its way out.
// Reset clears both valid flags and the parse state to the key phase.
// A stall on the output holds the result register; the input register still fills
// while empty, and the input stalls only when both registers hold words.
module metric_line_tokenizer_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_data_byte,
    input  logic       i_last_of_message,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_out_byte,
    output logic [2:0] o_byte_role,
    output logic       o_sample_done,
    output logic [2:0] o_error_code,
    output logic       o_message_done
);
    import mlt_pkg::*;

    logic         r_in_valid;
    logic [7:0]   r_in_byte;
    logic         r_in_last;
    logic         r_out_valid;
    logic [7:0]   r_out_byte;
    t_tag         r_out_tag;
    logic         r_out_last;
    t_parse_state r_state;
    t_parse_state n_state;
    t_tag         n_tag;
    logic         out_free;
    logic         advance;
    logic         in_take;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign advance    = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign in_take    = i_in_valid && !o_in_stall;

    mlt_step u_step (
        .i_state     (r_state),
        .i_data_byte (r_in_byte),
        .i_last      (r_in_last),
        .o_state     (n_state),
        .o_tag       (n_tag)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '{phase: PH_KEY, split_seen: 1'b0, value_nonempty: 1'b0};
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (out_free) begin
                r_out_valid <= r_in_valid;
            end
            if (advance) begin
                r_state <= n_state;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_byte <= i_data_byte;
            r_in_last <= i_last_of_message;
        end
        if (advance) begin
            r_out_byte <= r_in_byte;
            r_out_tag  <= n_tag;
            r_out_last <= r_in_last;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_out_byte     = r_out_byte;
    assign o_byte_role    = r_out_tag.role;
    assign o_sample_done  = r_out_tag.sample_done;
    assign o_error_code   = r_out_tag.error_code;
    assign o_message_done = r_out_last;

`ifndef NO_ASSERTIONS
    // an error before the last byte always drops the byte that raised it
    a_err_drops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out_tag.error_code != ERR_NONE) && !r_out_last
        |-> r_out_tag.role == ROLE_DROP)
        else $error("error tag on a byte that is not dropped");

    // a sample completes only on a line end or on the last byte of a message
    a_done_role: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_tag.sample_done
        |-> (r_out_tag.role == ROLE_DELIM) || r_out_last)
        else $error("sample done on an unexpected byte");

    // the parse state returns to the key phase after a message ends
    a_msg_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_in_last
        |=> (r_state.phase == PH_KEY) && !r_state.split_seen && !r_state.value_nonempty)
        else $error("state not reset at message end");

    // a label value cannot exist without its split
    a_split_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.value_nonempty |-> r_state.split_seen)
        else $error("label value seen without split");
`endif

endmodule

@@ rtl/core/mlt_step.sv @@
// Per-byte tagging logic: current parse state and one byte in, tag and next state out.
module mlt_step (
    input  mlt_pkg::t_parse_state i_state,
    input  logic [7:0]            i_data_byte,
    input  logic                  i_last,
    output mlt_pkg::t_parse_state o_state,
    output mlt_pkg::t_tag         o_tag
);
    import mlt_pkg::*;

    logic   line_end;
    logic   label_ok;
    t_phase phase_eff;
    t_parse_state st;
    t_role  role;
    t_err   err;
    logic   done;

    assign line_end = (i_data_byte == CH_LF) || (i_data_byte == CH_CR);
    assign label_ok = i_state.split_seen && i_state.value_nonempty;

    always_comb begin
        // a non line-end byte after a line end starts the next key
        phase_eff = i_state.phase;
        if (i_state.phase == PH_LINEEND && !line_end) begin
            phase_eff = PH_KEY;
        end
        st       = i_state;
        st.phase = phase_eff;
        role     = ROLE_DROP;
        err      = ERR_NONE;
        done     = 1'b0;

        unique case (phase_eff)
            PH_KEY: begin
                if (i_data_byte == CH_LBRACK) begin
                    role = ROLE_DELIM;
                    st   = '{phase: PH_LABEL, split_seen: 1'b0, value_nonempty: 1'b0};
                end else if (i_data_byte == CH_COLON || i_data_byte == CH_NUL) begin
                    role     = ROLE_DELIM;
                    st.phase = PH_VALUE;
                end else if (i_data_byte == CH_EQUALS) begin
                    err = ERR_KEY_EQUALS;
                end else begin
                    role = ROLE_KEY;
                end
            end
            PH_LABEL: begin
                if (i_data_byte == CH_RBRACK || i_data_byte == CH_COLON
                    || i_data_byte == CH_NUL) begin
                    if (label_ok) begin
                        role     = ROLE_DELIM;
                        st.phase = PH_AFTER;
                    end else begin
                        err = ERR_BAD_LABEL;
                    end
                end else if (!i_state.split_seen && i_data_byte == CH_EQUALS) begin
                    st.split_seen = 1'b1;
                    role          = ROLE_DELIM;
                end else if (i_state.split_seen) begin
                    st.value_nonempty = 1'b1;
                    role              = ROLE_LVAL;
                end else begin
                    role = ROLE_LKEY;
                end
            end
            PH_AFTER: begin
                if (i_data_byte == CH_LBRACK) begin
                    role = ROLE_DELIM;
                    st   = '{phase: PH_LABEL, split_seen: 1'b0, value_nonempty: 1'b0};
                end else if (i_data_byte == CH_COLON) begin
                    role     = ROLE_DELIM;
                    st.phase = PH_VALUE;
                end else begin
                    err = ERR_AFTER_LBL;
                end
            end
            PH_VALUE: begin
                if (line_end) begin
                    role     = ROLE_DELIM;
                    done     = 1'b1;
                    st.phase = PH_LINEEND;
                end else begin
                    role = ROLE_VALUE;
                end
            end
            PH_LINEEND: begin
                role = ROLE_DELIM;
            end
            default: begin
                role = ROLE_DROP;
            end
        endcase

        if (err != ERR_NONE) begin
            role     = ROLE_DROP;
            st.phase = PH_DISCARD;
        end

        if (i_last) begin
            if (err == ERR_NONE) begin
                unique case (st.phase)
                    PH_KEY:   err = ERR_INCOMPLETE;
                    PH_LABEL: err = (st.split_seen && st.value_nonempty)
                                    ? ERR_INCOMPLETE : ERR_BAD_LABEL;
                    PH_AFTER: err = ERR_AFTER_LBL;
                    PH_VALUE: done = 1'b1;
                    default:  err = ERR_NONE;
                endcase
            end
            // message end: back to the reset state
            st = '{phase: PH_KEY, split_seen: 1'b0, value_nonempty: 1'b0};
        end

        o_state = st;
        o_tag   = '{role: role, sample_done: done, error_code: err};
    end

endmodule
